// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro takes a label, the clock,
// the active-low reset and the two sides of the implication.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ===== hdl/cws_pkg.sv =====
package cws_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic load;   // insert the broadcast word at its sorted place
        logic drain;  // shift the whole row one place toward cell 0
    } cell_ctrl_t;

endpackage

// ===== hdl/cws_cell.sv =====
module cws_cell #(
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                clk,
    input  cws_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]    count,
    input  cws_pkg::word_t      word,
    input  cws_pkg::word_t      left_value,
    input  logic                left_gt,
    input  cws_pkg::word_t      right_value,
    output cws_pkg::word_t      value,
    output logic                gt
);

    localparam logic [CNT_W:0] IDX = (CNT_W + 1)'(CELL_IDX);

    cws_pkg::word_t value_reg;
    cws_pkg::word_t value_next;
    logic           is_empty;

    // A cell at or beyond the fill count holds nothing and sorts above any word.
    assign is_empty = ({1'b0, count} <= IDX);
    assign gt       = is_empty || (value_reg > word);
    assign value    = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load && gt)
        begin
            // The first cell above the new word takes it; the rest shift right.
            if (left_gt)
            begin
                value_next = left_value;
            end
            else
            begin
                value_next = word;
            end
        end
        else if (ctrl.drain)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== hdl/chunk_word_sorter_top.sv =====
// Chunk word sorter. Unsigned 32-bit words arrive on the slave stream, one
// request per cycle, and are kept in ascending order in a row of
// CHUNK_WORDS sorting cells as they arrive. The request with tlast set closes
// the chunk; from the next cycle the stored words leave on the master stream
// smallest first, one per cycle while tready is high, with tlast on the
// largest. Words beyond CHUNK_WORDS are dropped and every result of that chunk
// then has tuser set. No word is taken while the chunk unloads, because the
// same cell row does the insertion and the shifting out.
`include "assert_macros.svh"

module chunk_word_sorter_top #(
    parameter int CHUNK_WORDS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] word_value
    input  logic        s_tlast,   // final_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,   // last_out
    output logic        m_tuser    // [0] overflowed
);

    localparam int CNT_W = $clog2(CHUNK_WORDS + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CHUNK_WORDS);
    localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);

    cws_pkg::state_t     state_reg;
    cws_pkg::state_t     state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                dropped_reg;
    logic                dropped_next;
    cws_pkg::cell_ctrl_t ctrl;
    logic                in_req;
    logic                out_req;
    logic                has_room;

    cws_pkg::word_t      cell_value [CHUNK_WORDS];
    logic                cell_gt    [CHUNK_WORDS];

    assign s_tready = (state_reg == cws_pkg::ST_LOAD);
    assign m_tvalid = (state_reg == cws_pkg::ST_DRAIN);
    assign m_tdata  = cell_value[0];
    assign m_tlast  = (count_reg == ONE_COUNT);
    assign m_tuser  = dropped_reg;

    assign in_req   = s_tvalid && s_tready;
    assign out_req  = m_tvalid && m_tready;
    assign has_room = (count_reg < FULL_COUNT);

    assign ctrl.load  = in_req && has_room;
    assign ctrl.drain = out_req;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        unique case (state_reg)
            cws_pkg::ST_LOAD:
            begin
                if (in_req)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + ONE_COUNT;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = cws_pkg::ST_DRAIN;
                    end
                end
            end
            cws_pkg::ST_DRAIN:
            begin
                if (out_req)
                begin
                    count_next = count_reg - ONE_COUNT;
                    if (m_tlast)
                    begin
                        dropped_next = 1'b0;
                        state_next   = cws_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = cws_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cws_pkg::ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CHUNK_WORDS; gi++)
        begin : g_cell
            cws_pkg::word_t left_value;
            logic           left_gt;
            cws_pkg::word_t right_value;

            if (gi == 0)
            begin : g_first
                assign left_value = '0;
                assign left_gt    = 1'b0;
            end
            else
            begin : g_inner
                assign left_value = cell_value[gi-1];
                assign left_gt    = cell_gt[gi-1];
            end

            if (gi == CHUNK_WORDS - 1)
            begin : g_last
                assign right_value = '0;
            end
            else
            begin : g_mid
                assign right_value = cell_value[gi+1];
            end

            cws_cell #(
                .CNT_W    (CNT_W),
                .CELL_IDX (gi)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .count       (count_reg),
                .word        (s_tdata),
                .left_value  (left_value),
                .left_gt     (left_gt),
                .right_value (right_value),
                .value       (cell_value[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    `ASSERT_SAME(a_drain_not_empty, clk, rst_n, m_tvalid, count_reg != '0)
    `ASSERT_SAME(a_count_in_range, clk, rst_n, 1'b1, count_reg <= FULL_COUNT)
    `ASSERT_NEXT(a_close_starts_drain, clk, rst_n, in_req && s_tlast, m_tvalid)
    `ASSERT_NEXT(a_last_frees_input, clk, rst_n, out_req && m_tlast,
        s_tready && count_reg == '0 && !dropped_reg)

endmodule
